// ----- design/ffd_pkg.sv -----
package ffd_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 65536;
  localparam int SAMPLE_BITS          = 16;

  localparam int FB_SCALE  = 64225;
  localparam int BASE_TIME = 12884902;
  localparam int MOD_TIME  = 8589935;

  localparam logic [17:0] RST_SAMPLE_RATE = 18'd48000;
  localparam logic [16:0] RST_WET_MIX     = 17'd32768;
  localparam logic [15:0] RST_SMOOTH_COEF = 16'd131;

  typedef enum logic [2:0] {
    REG_SAMPLE_RATE  = 3'd0,
    REG_DELAY_TIME   = 3'd1,
    REG_FEEDBACK     = 3'd2,
    REG_WET_MIX      = 3'd3,
    REG_MODE         = 3'd4,
    REG_SMOOTH_COEF  = 3'd5
  } ffd_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMOOTH_MUL,
    ST_SMOOTH_UPD,
    ST_DELAY_MUL,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_COMMIT,
    ST_MIX,
    ST_EMIT
  } ffd_state_t;

  typedef struct packed {
    logic load;
    logic smooth_mul;
    logic smooth_upd;
    logic delay_mul;
    logic addr;
    logic rd0;
    logic rd1;
    logic interp;
    logic commit;
    logic mix;
    logic emit;
  } ffd_cmd_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [39:0] x);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd1 <<< (SAMPLE_BITS - 1);
    hi = hi - 40'sd1;
    lo = -hi - 40'sd1;
    if (x > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (x < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return x[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ----- design/ffd_ctrl.sv -----
module ffd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output ffd_pkg::ffd_cmd_t cmd
);
  import ffd_pkg::*;

  ffd_state_t state;
  ffd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SMOOTH_MUL;
        end
      end
      ST_SMOOTH_MUL: begin
        cmd.smooth_mul = 1'b1;
        state_next     = ST_SMOOTH_UPD;
      end
      ST_SMOOTH_UPD: begin
        cmd.smooth_upd = 1'b1;
        state_next     = ST_DELAY_MUL;
      end
      ST_DELAY_MUL: begin
        cmd.delay_mul = 1'b1;
        state_next    = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd0    = 1'b1;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- design/ffd_dp.sv -----
module ffd_dp #(
  parameter int BUFFER_DEPTH = ffd_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  ffd_pkg::ffd_cmd_t cmd,
  input  logic [31:0]       s_tdata,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [17:0]       cfg_data,
  output logic [15:0]       out_data
);
  import ffd_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = (AW + 17 > 35) ? AW + 17 : 35;
  localparam logic [PW-1:0] MAXD     = PW'(BUFFER_DEPTH - 2) << 16;
  localparam logic [PW-1:0] WRAPD    = PW'(BUFFER_DEPTH) << 16;
  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

  // configuration
  logic [17:0] sample_rate;
  logic [15:0] delay_time;
  logic [15:0] feedback_amount;
  logic [16:0] wet_mix;
  logic        mode;
  logic [15:0] smoothing_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate     <= RST_SAMPLE_RATE;
      delay_time      <= '0;
      feedback_amount <= '0;
      wet_mix         <= RST_WET_MIX;
      mode            <= 1'b0;
      smoothing_coef  <= RST_SMOOTH_COEF;
    end else if (cfg_we) begin
      unique case (ffd_reg_t'(cfg_index))
        REG_SAMPLE_RATE: sample_rate     <= cfg_data;
        REG_DELAY_TIME:  delay_time      <= cfg_data[15:0];
        REG_FEEDBACK:    feedback_amount <= cfg_data[15:0];
        REG_WET_MIX:     wet_mix         <= cfg_data[16:0];
        REG_MODE:        mode            <= cfg_data[0];
        REG_SMOOTH_COEF: smoothing_coef  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  logic signed [15:0] audio;
  logic [31:0]        target;
  logic [31:0]        smoothed;
  logic [48:0]        pa;
  logic [47:0]        pb;
  logic [31:0]        fbp;
  logic [15:0]        fbg;
  logic [49:0]        dprod;
  logic [AW-1:0]      i0;
  logic [AW-1:0]      i1;
  logic [15:0]        tfrac;
  logic [AW-1:0]      wi;
  logic               wrapped;
  logic [SAMPLE_BITS-1:0] mem_q;
  logic               rd_ok;
  logic signed [15:0] y0;
  logic signed [15:0] y;
  logic signed [15:0] last_dly;
  logic signed [33:0] p0;
  logic signed [33:0] p1;
  logic signed [32:0] pfb;
  logic signed [33:0] pdry;
  logic signed [33:0] pwet;

  logic [SAMPLE_BITS-1:0] mem [0:BUFFER_DEPTH-1];

  // combinational helpers
  logic [39:0]        mprod;
  logic [31:0]        tgt_mod;
  logic [16:0]        coef_c;
  logic [49:0]        sum_s;
  logic [32:0]        fbg_sum;
  logic [PW-1:0]      dly;
  logic [PW-1:0]      dly_c;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      pos_w;
  logic [AW-1:0]      i1_new;
  logic [AW-1:0]      rd_addr;
  logic [16:0]        wet_c;
  logic [16:0]        dry_c;
  logic [16:0]        w0;
  logic signed [15:0] rd_val;
  logic signed [39:0] y_pre;
  logic signed [39:0] wr_pre;
  logic signed [39:0] out_pre;

  assign mprod   = {24'd0, s_tdata[31:16] ^ 16'h8000} * 40'(MOD_TIME);
  assign tgt_mod = 32'(BASE_TIME - MOD_TIME) + 32'(mprod[39:15]);
  assign coef_c  = 17'd65536 - {1'b0, smoothing_coef};
  assign sum_s   = {1'b0, pa} + {2'b0, pb};
  assign fbg_sum = {1'b0, fbp} + 33'd32768;

  assign dly    = PW'(dprod[49:16]);
  assign dly_c  = (dly > MAXD) ? MAXD : dly;
  assign pos    = (PW'(wi) << 16) - dly_c;
  assign pos_w  = pos[PW-1] ? pos + WRAPD : pos;
  assign i1_new = pos_w[AW+15:16];

  assign rd_addr = cmd.rd0 ? i0 : i1;
  assign rd_val  = rd_ok ? $signed(mem_q) : 16'sd0;

  assign wet_c = (wet_mix > 17'd65536) ? 17'd65536 : wet_mix;
  assign dry_c = 17'd65536 - wet_c;
  assign w0    = 17'd65536 - {1'b0, tfrac};

  assign y_pre   = (p0 + p1 + 40'sd32768) >>> 16;
  assign wr_pre  = audio + ((pfb + 40'sd32768) >>> 16);
  assign out_pre = (pdry + pwet + 40'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      audio  <= $signed(s_tdata[15:0]);
      target <= mode ? tgt_mod : {delay_time, 16'h0000};
    end
    if (cmd.smooth_mul) begin
      pa  <= {32'd0, coef_c} * {17'd0, smoothed};
      pb  <= {32'd0, smoothing_coef} * {16'd0, target};
      fbp <= {16'd0, feedback_amount} * 32'(FB_SCALE);
    end
    if (cmd.smooth_upd) begin
      fbg <= fbg_sum[31:16];
    end
    if (cmd.delay_mul) begin
      dprod <= {18'd0, smoothed} * {32'd0, sample_rate};
    end
    if (cmd.addr) begin
      i1    <= i1_new;
      i0    <= (i1_new == '0) ? LAST_IDX : i1_new - 1'b1;
      tfrac <= pos_w[15:0];
    end
    if (cmd.rd0 || cmd.rd1) begin
      rd_ok <= wrapped || (rd_addr < wi);
    end
    if (cmd.rd1) begin
      y0 <= rd_val;
    end
    if (cmd.interp) begin
      p0   <= y0 * $signed({1'b0, w0});
      p1   <= rd_val * $signed({2'b00, tfrac});
      pfb  <= last_dly * $signed({1'b0, fbg});
      pdry <= audio * $signed({1'b0, dry_c});
    end
    if (cmd.commit) begin
      y <= sat_sample(y_pre);
    end
    if (cmd.mix) begin
      pwet <= y * $signed({1'b0, wet_c});
    end
    if (cmd.emit) begin
      out_data <= sat_sample(out_pre);
    end
  end

  // delay memory: one read or write per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd0 || cmd.rd1) begin
      mem_q <= mem[rd_addr];
    end
    if (cmd.commit) begin
      mem[wi] <= sat_sample(wr_pre);
    end
  end

  // entries at or past wi are unwritten until the first wrap and read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      last_dly <= '0;
      wi       <= '0;
      wrapped  <= 1'b0;
    end else begin
      if (cmd.smooth_upd) begin
        smoothed <= sum_s[47:16];
      end
      if (cmd.emit) begin
        last_dly <= y;
        if (wi == LAST_IDX) begin
          wi      <= '0;
          wrapped <= 1'b1;
        end else begin
          wi <= wi + 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/fractional_feedback_delay_unit.sv -----
// Steps: load, smooth multiply and update, delay multiply, address, two tap reads (rd0, rd1),
// interpolate, commit (one write), mix, emit; emit waits while a pending result sees m_tready low.
// One transaction at a time, set by these steps on the single-port delay memory.
// Reset: synchronous, clears controller, write index, smoothed time and feedback sample;
// memory entries not yet written since reset read as zero, so no clearing pass is needed.
module fractional_feedback_delay_unit #(
  parameter int BUFFER_DEPTH = ffd_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] audio_in, [31:16] modulation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] audio_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import ffd_pkg::*;

  ffd_cmd_t cmd;

  ffd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ffd_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_tdata)
  );

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result emitted over a pending one");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted result not presented");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transaction accepted while busy");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath step issued");

endmodule

// ----- tb/fractional_feedback_delay_unit_tb.sv -----
`timescale 1ns / 1ps

module fractional_feedback_delay_unit_tb;
  import ffd_pkg::*;

  localparam int DEPTH = ffd_pkg::DEFAULT_BUFFER_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int IDLE_PCT = 14;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] audio_in, [31:16] modulation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [15:0] audio_out
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  fractional_feedback_delay_unit #(.BUFFER_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // delay line shadow state and register copy
  logic signed [15:0] delay_line [DEPTH];
  int                 write_ptr = 0;
  logic [31:0]        smooth_time = '0;
  logic signed [15:0] last_tap = '0;
  logic [17:0]        rate_cfg = RST_SAMPLE_RATE;
  logic [15:0]        delay_cfg = '0;
  logic [15:0]        feedback_cfg = '0;
  logic [16:0]        wet_cfg = RST_WET_MIX;
  logic               mode_cfg = 1'b0;
  logic [15:0]        coef_cfg = RST_SMOOTH_COEF;

  logic [31:0] pending_samples [$];
  logic [15:0] expected_samples [$];
  int accepted_count = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int rx_hold_left = 0;
  bit rx_hold_armed = 1'b1;
  bit calm;

  assign calm = (accepted_count >= 800) && (accepted_count < 1000);

  function automatic longint round_q16(input longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic logic signed [15:0] clamp_sample(input longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic logic [15:0] advance_delay_line(input logic signed [15:0] audio,
                                                     input logic signed [15:0] modv);
    longint target, dly, pos, t, y, fbg, wet;
    int tap1, tap0;
    if (mode_cfg)
      target = longint'(BASE_TIME - MOD_TIME) +
               (((longint'(modv) + 32768) * longint'(MOD_TIME)) >>> 15);
    else
      target = longint'(delay_cfg) << 16;
    smooth_time = 32'(((65536 - longint'(coef_cfg)) * longint'(smooth_time) +
                       longint'(coef_cfg) * target) >>> 16);
    dly = (longint'(smooth_time) * longint'(rate_cfg)) >>> 16;
    if (dly > (longint'(DEPTH - 2) << 16)) dly = longint'(DEPTH - 2) << 16;
    pos = (longint'(write_ptr) << 16) - dly;
    if (pos < 0) pos += longint'(DEPTH) << 16;
    tap1 = int'(pos >>> 16);
    t = pos & 64'hFFFF;
    if (tap1 >= DEPTH) tap1 -= DEPTH;
    tap0 = (tap1 == 0) ? DEPTH - 1 : tap1 - 1;
    y = round_q16(longint'(delay_line[tap0]) * (65536 - t) +
                  longint'(delay_line[tap1]) * t);
    fbg = (longint'(feedback_cfg) * longint'(FB_SCALE) + 32768) >>> 16;
    delay_line[write_ptr] = clamp_sample(longint'(audio) +
                                         round_q16(longint'(last_tap) * fbg));
    last_tap = clamp_sample(y);
    wet = (wet_cfg > 17'd65536) ? 65536 : longint'(wet_cfg);
    write_ptr = (write_ptr + 1 >= DEPTH) ? 0 : write_ptr + 1;
    return clamp_sample(round_q16(longint'(audio) * (65536 - wet) +
                                  longint'(last_tap) * wet));
  endfunction

  task automatic report_mismatch(input logic [15:0] got, input logic [15:0] want);
    $display("ERROR t=%0t sample %0d: audio_out got %0d expected %0d", $time,
             results_seen, $signed(got), $signed(want));
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SAMPLE_RATE: rate_cfg = data;
      REG_DELAY_TIME:  delay_cfg = data[15:0];
      REG_FEEDBACK:    feedback_cfg = data[15:0];
      REG_WET_MIX:     wet_cfg = data[16:0];
      REG_MODE:        mode_cfg = data[0];
      REG_SMOOTH_COEF: coef_cfg = data[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_item(input logic [15:0] audio, input logic [15:0] modv);
    pending_samples.push_back({modv, audio});
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_samples.push_back(advance_delay_line(s_tdata[15:0], s_tdata[31:16]));
        accepted_count <= accepted_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_samples.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, mid-run
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
      rx_hold_armed <= 1'b1;
    end else if (rx_hold_armed && results_seen == 500) begin
      rx_hold_left <= 600;
      rx_hold_armed <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (rx_hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // receiver check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch(m_tdata, 'x);
      end else begin
        if (m_tdata !== expected_samples[0]) report_mismatch(m_tdata, expected_samples[0]);
        void'(expected_samples.pop_front());
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0] audio;
    int pick;
    foreach (delay_line[i]) delay_line[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings, zero delay
    queue_item(16'h7FFF, 16'h8000);
    queue_item(16'h8000, 16'h7FFF);
    queue_item(16'h0000, 16'h0000);
    queue_item(16'hFFFF, 16'hFFFF);
    drain();

    // wet above unity, max feedback, long delay, spare indexes
    write_reg(REG_WET_MIX, 18'h1FFFF);
    write_reg(REG_FEEDBACK, 18'hFFFF);
    write_reg(REG_SMOOTH_COEF, 18'hFFFF);
    write_reg(REG_DELAY_TIME, 18'hFFFF);
    write_reg(REG_SAMPLE_RATE, 18'd192000);
    write_reg(REG_SPARE_LO, 18'h3FFFF);
    write_reg(REG_SPARE_HI, 18'h3FFFF);
    queue_item(16'h7FFF, 16'h5555);
    queue_item(16'h8000, 16'hAAAA);
    queue_item(16'h7FFF, 16'h0001);
    queue_item(16'h8001, 16'hFFFE);
    drain();

    // zero sample rate, frozen smoother, chorus, fully dry
    write_reg(REG_SAMPLE_RATE, 18'd0);
    write_reg(REG_SMOOTH_COEF, 18'd0);
    write_reg(REG_MODE, 18'd1);
    write_reg(REG_WET_MIX, 18'd0);
    queue_item(16'h1234, 16'h8000);
    queue_item(16'hEDCB, 16'h7FFF);
    queue_item(16'h7FFF, 16'h0000);
    queue_item(16'h8000, 16'hFFFF);
    drain();

    // chorus sweep, fully wet
    write_reg(REG_SAMPLE_RATE, 18'd48000);
    write_reg(REG_SMOOTH_COEF, 18'd65535);
    write_reg(REG_WET_MIX, 18'd65536);
    write_reg(REG_FEEDBACK, 18'd32768);
    queue_item(16'h7FFF, 16'h8000);
    queue_item(16'h8000, 16'h7FFF);
    queue_item(16'h4000, 16'h0000);
    queue_item(16'hC000, 16'hC000);
    queue_item(16'h7FFF, 16'h4000);
    queue_item(16'h8000, 16'h8000);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(9);
      case (pick)
        0: write_reg(REG_SAMPLE_RATE, 18'd8000);
        1: write_reg(REG_SAMPLE_RATE, 18'd192000);
        2: write_reg(REG_SAMPLE_RATE, 18'd44100);
        3: write_reg(REG_SAMPLE_RATE, 18'd96000);
        4: write_reg(REG_SAMPLE_RATE, 18'($urandom_range(8000, 192000)));
        5: write_reg(REG_SAMPLE_RATE, 18'($urandom_range(0, 18'h3FFFF)));
        default: write_reg(REG_SAMPLE_RATE, 18'd48000);
      endcase
      if ($urandom_range(4) == 0) write_reg(REG_DELAY_TIME, 18'($urandom_range(0, 65535)));
      else write_reg(REG_DELAY_TIME, 18'($urandom_range(0, 1500)));
      write_reg(REG_FEEDBACK, 18'($urandom_range(0, 65535)));
      if ($urandom_range(7) == 0) write_reg(REG_WET_MIX, 18'($urandom_range(65537, 131071)));
      else write_reg(REG_WET_MIX, 18'($urandom_range(0, 65536)));
      write_reg(REG_MODE, 18'($urandom_range(0, 18'h3FFFF)));
      if ($urandom_range(9) == 0) write_reg(REG_SMOOTH_COEF, 18'($urandom_range(0, 65535)));
      else write_reg(REG_SMOOTH_COEF, 18'($urandom_range(2000, 65535)));
      if ($urandom_range(1) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                  18'($urandom_range(0, 18'h3FFFF)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(9);
        if (pick < 7) audio = 16'($urandom_range(0, 65535));
        else if (pick < 9) audio = 16'($signed(17'($urandom_range(0, 4095))) - 17'sd2048);
        else audio = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        queue_item(audio, 16'($urandom_range(0, 65535)));
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
